/* rtl/ftmc_pkg.sv */
// Shared types, codes and a helper function of the fan thermal mode controller.
`timescale 1ns / 1ps

package ftmc_pkg;

   localparam int CFG_WIDTH  = 16;
   localparam int TEMP_WIDTH = 9;

   // Configuration register indexes.
   localparam logic [2:0] REG_SCAN_PERIOD      = 3'd0;
   localparam logic [2:0] REG_PERSIST_LIMIT    = 3'd1;
   localparam logic [2:0] REG_LOG_PERIOD       = 3'd2;
   localparam logic [2:0] REG_PURGE_DELAY      = 3'd3;
   localparam logic [2:0] REG_PURGE_LENGTH     = 3'd4;
   localparam logic [2:0] REG_ALARM_THRESHOLD  = 3'd5;
   localparam logic [2:0] REG_HIGH_THRESHOLD   = 3'd6;
   localparam logic [2:0] REG_NORMAL_THRESHOLD = 3'd7;

   // Reset values of the thresholds.
   localparam logic signed [TEMP_WIDTH-1:0] ALARM_RESET  = 9'sd90;
   localparam logic signed [TEMP_WIDTH-1:0] HIGH_RESET   = 9'sd70;
   localparam logic signed [TEMP_WIDTH-1:0] NORMAL_RESET = 9'sd50;

   // Operating mode, held one-hot.
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_PURGE = 4'b0010,
      MODE_ALARM = 4'b0100,
      MODE_HIGH  = 4'b1000
   } mode_type;

   // Codes reported on the mode_now field.
   localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CODE_PURGE = 2'd1;
   localparam logic [1:0] MODE_CODE_ALARM = 2'd2;
   localparam logic [1:0] MODE_CODE_HIGH  = 2'd3;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_PURGE_START = 3'd1,
      EV_ALARM_ENTER = 3'd2,
      EV_HIGH_ENTER  = 3'd3,
      EV_ESCALATED   = 3'd4,
      EV_NORMAL      = 3'd5
   } event_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]         scan_period;
      logic [CFG_WIDTH-1:0]         persist_limit;
      logic [CFG_WIDTH-1:0]         log_period;
      logic [CFG_WIDTH-1:0]         purge_delay;
      logic [CFG_WIDTH-1:0]         purge_length;
      logic signed [TEMP_WIDTH-1:0] alarm_threshold;
      logic signed [TEMP_WIDTH-1:0] high_threshold;
      logic signed [TEMP_WIDTH-1:0] normal_threshold;
   } cfg_type;

   // Mode, fan levels, LED and halt flag kept between ticks.
   typedef struct packed {
      mode_type mode;
      logic     fan_cpu;
      logic     fan_supply;
      logic     fan_front;
      logic     fan_rear;
      logic     led;
      logic     halted;
   } flags_type;

   // Result item; the first field sits in the highest bit.
   typedef struct packed {
      logic       shutdown;
      event_type  event_code;
      logic       purge_finished;
      logic       log_strobe;
      logic       scanned;
      logic [1:0] mode_now;
      logic       led_level;
      logic       fan_rear;
      logic       fan_front;
      logic       fan_supply;
      logic       fan_cpu;
   } result_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] code;
      case (m)
         MODE_IDLE:  code = MODE_CODE_IDLE;
         MODE_PURGE: code = MODE_CODE_PURGE;
         MODE_ALARM: code = MODE_CODE_ALARM;
         MODE_HIGH:  code = MODE_CODE_HIGH;
         default:    code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* rtl/ftmc_step.sv */
// Next-state and result logic for one loop tick of the fan controller.
`timescale 1ns / 1ps

module ftmc_step #(
   parameter int COUNT_WIDTH = 16
) (
   input  ftmc_pkg::cfg_type                      cfg,
   input  logic signed [ftmc_pkg::TEMP_WIDTH-1:0] temperature,
   input  ftmc_pkg::flags_type                    flags_cur,
   input  logic [COUNT_WIDTH-1:0]                 scan_cur,
   input  logic [COUNT_WIDTH-1:0]                 log_cur,
   input  logic [COUNT_WIDTH-1:0]                 pwait_cur,
   input  logic [COUNT_WIDTH-1:0]                 prun_cur,
   input  logic [COUNT_WIDTH-1:0]                 oheat_cur,
   output ftmc_pkg::flags_type                    flags_nxt,
   output logic [COUNT_WIDTH-1:0]                 scan_nxt,
   output logic [COUNT_WIDTH-1:0]                 log_nxt,
   output logic [COUNT_WIDTH-1:0]                 pwait_nxt,
   output logic [COUNT_WIDTH-1:0]                 prun_nxt,
   output logic [COUNT_WIDTH-1:0]                 oheat_nxt,
   output ftmc_pkg::result_type                   result
);

   // Counters and periods are compared at the wider of the two widths.
   localparam int CMP_W = (COUNT_WIDTH > ftmc_pkg::CFG_WIDTH) ?
                          COUNT_WIDTH : ftmc_pkg::CFG_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   function automatic logic below(input logic [COUNT_WIDTH-1:0] cnt,
                                  input logic [ftmc_pkg::CFG_WIDTH-1:0] lim);
      return CMP_W'(cnt) < CMP_W'(lim);
   endfunction

   ftmc_pkg::flags_type  f;
   ftmc_pkg::event_type  ev;
   logic                 done;
   logic                 scanned;
   logic                 strobe;
   logic                 pfin;
   logic                 at_alarm;
   logic                 at_high;
   logic                 at_normal;

   assign at_alarm  = temperature >= cfg.alarm_threshold;
   assign at_high   = temperature >= cfg.high_threshold;
   assign at_normal = temperature <= cfg.normal_threshold;

   always_comb begin
      f         = flags_cur;
      scan_nxt  = scan_cur;
      log_nxt   = log_cur;
      pwait_nxt = pwait_cur;
      prun_nxt  = prun_cur;
      oheat_nxt = oheat_cur;
      ev        = ftmc_pkg::EV_NONE;
      done      = 1'b0;
      scanned   = 1'b0;
      strobe    = 1'b0;
      pfin      = 1'b0;

      if (!flags_cur.halted) begin
         // Purge expiry is checked on every tick that is not halted, waiting ticks included.
         if (f.mode == ftmc_pkg::MODE_PURGE) begin
            if (below(prun_nxt, cfg.purge_length)) begin
               prun_nxt = prun_nxt + CNT_ONE;
            end else begin
               prun_nxt    = '0;
               f.mode      = ftmc_pkg::MODE_IDLE;
               f.fan_rear  = ~f.fan_rear;
               f.fan_front = ~f.fan_front;
               pfin        = 1'b1;
            end
         end

         if (below(scan_nxt, cfg.scan_period)) begin
            f.led    = ~f.led;
            scan_nxt = scan_nxt + CNT_ONE;
            done     = 1'b1;
         end else begin
            scan_nxt = '0;
            scanned  = 1'b1;
            if (below(log_nxt, cfg.log_period)) begin
               log_nxt = log_nxt + CNT_ONE;
            end else begin
               log_nxt = '0;
               strobe  = 1'b1;
            end
         end

         // Alarm entry from any other mode.
         if (!done && f.mode != ftmc_pkg::MODE_ALARM && at_alarm) begin
            case (f.mode)
               ftmc_pkg::MODE_IDLE: begin
                  f.fan_cpu    = ~f.fan_cpu;
                  f.fan_supply = ~f.fan_supply;
                  f.fan_front  = ~f.fan_front;
                  f.fan_rear   = ~f.fan_rear;
               end
               ftmc_pkg::MODE_PURGE: begin
                  f.fan_cpu    = ~f.fan_cpu;
                  f.fan_supply = ~f.fan_supply;
               end
               default: begin
                  f.fan_front  = ~f.fan_front;
                  f.fan_supply = ~f.fan_supply;
               end
            endcase
            f.mode    = ftmc_pkg::MODE_ALARM;
            oheat_nxt = '0;
            ev        = ftmc_pkg::EV_ALARM_ENTER;
            done      = 1'b1;
         end

         // Overheat persisting in alarm mode; once the count reaches the limit the block halts.
         if (!done && f.mode == ftmc_pkg::MODE_ALARM && at_alarm) begin
            if (below(oheat_nxt, cfg.persist_limit)) begin
               oheat_nxt = oheat_nxt + CNT_ONE;
            end else begin
               f.halted = 1'b1;
               done     = 1'b1;
            end
         end

         // High entry from idle or purge.
         if (!done && (f.mode == ftmc_pkg::MODE_IDLE || f.mode == ftmc_pkg::MODE_PURGE)
             && at_high) begin
            if (f.mode == ftmc_pkg::MODE_IDLE) begin
               f.fan_cpu  = ~f.fan_cpu;
               f.fan_rear = ~f.fan_rear;
            end else begin
               f.fan_front = ~f.fan_front;
               f.fan_cpu   = ~f.fan_cpu;
            end
            f.mode    = ftmc_pkg::MODE_HIGH;
            oheat_nxt = '0;
            ev        = ftmc_pkg::EV_HIGH_ENTER;
            done      = 1'b1;
         end

         if (!done && f.mode == ftmc_pkg::MODE_HIGH) begin
            if (at_high && below(oheat_nxt, cfg.persist_limit)) begin
               oheat_nxt = oheat_nxt + CNT_ONE;
            end else if (at_alarm && !below(oheat_nxt, cfg.persist_limit)) begin
               oheat_nxt    = '0;
               f.mode       = ftmc_pkg::MODE_ALARM;
               f.fan_front  = ~f.fan_front;
               f.fan_supply = ~f.fan_supply;
               ev           = ftmc_pkg::EV_ESCALATED;
            end
         end

         if (!done && f.mode == ftmc_pkg::MODE_IDLE) begin
            if (below(pwait_nxt, cfg.purge_delay)) begin
               pwait_nxt = pwait_nxt + CNT_ONE;
            end else begin
               f.mode      = ftmc_pkg::MODE_PURGE;
               pwait_nxt   = '0;
               prun_nxt    = '0;
               f.fan_rear  = ~f.fan_rear;
               f.fan_front = ~f.fan_front;
               ev          = ftmc_pkg::EV_PURGE_START;
            end
         end

         if (!done && (f.mode == ftmc_pkg::MODE_ALARM || f.mode == ftmc_pkg::MODE_HIGH)
             && at_normal) begin
            if (f.mode == ftmc_pkg::MODE_ALARM) begin
               f.fan_cpu    = ~f.fan_cpu;
               f.fan_supply = ~f.fan_supply;
               f.fan_front  = ~f.fan_front;
               f.fan_rear   = ~f.fan_rear;
            end else begin
               f.fan_cpu  = ~f.fan_cpu;
               f.fan_rear = ~f.fan_rear;
            end
            f.mode = ftmc_pkg::MODE_IDLE;
            ev     = ftmc_pkg::EV_NORMAL;
         end
      end

      flags_nxt = f;

      result.fan_cpu        = f.fan_cpu;
      result.fan_supply     = f.fan_supply;
      result.fan_front      = f.fan_front;
      result.fan_rear       = f.fan_rear;
      result.led_level      = f.led;
      result.mode_now       = ftmc_pkg::mode_code(f.mode);
      result.scanned        = scanned;
      result.log_strobe     = strobe;
      result.purge_finished = pfin;
      result.event_code     = ev;
      result.shutdown       = f.halted;
   end

endmodule

/* rtl/fan_thermal_mode_controller_core.sv */
// Top level of the fan thermal mode controller: registers, handshakes and checks.
`timescale 1ns / 1ps

// Channel   Direction  Payload                               Transfer when
// req_      in         tdata[8:0] temperature (signed)       req_tvalid && req_tready
// rsp_      out        tdata[13:0] fans, LED, mode, events   rsp_tvalid && rsp_tready
// csr_      in         index 0..7, wdata 16 bits             csr_we
//
// Every tick is worked out in the cycle of its transfer: the mode, counter and
// fan registers take their next values at that edge and the result lands in
// the output register, so each result is valid in the cycle after its request.
// A new request is taken in every cycle while the output register is empty or
// being drained in the same cycle; a stalled result holds only the req_ side.
// Synchronous reset clears the mode to idle, all counters, fans, LED and the
// halt flag, and loads the thresholds with their defaults.

module fan_thermal_mode_controller_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] temperature, [15:9] zero
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] fan_cpu, [1] fan_supply, [2] fan_front,
                                    // [3] fan_rear, [4] led_level, [6:5] mode_now,
                                    // [7] scanned, [8] log_strobe, [9] purge_finished,
                                    // [12:10] event_code, [13] shutdown, [15:14] zero
   // Configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int RES_W = $bits(ftmc_pkg::result_type);

   ftmc_pkg::cfg_type    cfg_ff, cfg_in;
   ftmc_pkg::flags_type  flags_ff, flags_in;
   logic [COUNT_WIDTH-1:0] scan_ff, scan_in;
   logic [COUNT_WIDTH-1:0] log_ff, log_in;
   logic [COUNT_WIDTH-1:0] pwait_ff, pwait_in;
   logic [COUNT_WIDTH-1:0] prun_ff, prun_in;
   logic [COUNT_WIDTH-1:0] oheat_ff, oheat_in;
   ftmc_pkg::result_type result_ff, result_in;
   logic                   rsp_valid_ff;
   logic                   req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(16 - RES_W)'(0), result_ff};

   // Configuration registers. Thresholds keep the low nine bits of the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ftmc_pkg::REG_SCAN_PERIOD:      cfg_in.scan_period   = csr_wdata;
            ftmc_pkg::REG_PERSIST_LIMIT:    cfg_in.persist_limit = csr_wdata;
            ftmc_pkg::REG_LOG_PERIOD:       cfg_in.log_period    = csr_wdata;
            ftmc_pkg::REG_PURGE_DELAY:      cfg_in.purge_delay   = csr_wdata;
            ftmc_pkg::REG_PURGE_LENGTH:     cfg_in.purge_length  = csr_wdata;
            ftmc_pkg::REG_ALARM_THRESHOLD:
               cfg_in.alarm_threshold = csr_wdata[ftmc_pkg::TEMP_WIDTH-1:0];
            ftmc_pkg::REG_HIGH_THRESHOLD:
               cfg_in.high_threshold = csr_wdata[ftmc_pkg::TEMP_WIDTH-1:0];
            ftmc_pkg::REG_NORMAL_THRESHOLD:
               cfg_in.normal_threshold = csr_wdata[ftmc_pkg::TEMP_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_period      <= '0;
         cfg_ff.persist_limit    <= '0;
         cfg_ff.log_period       <= '0;
         cfg_ff.purge_delay      <= '0;
         cfg_ff.purge_length     <= '0;
         cfg_ff.alarm_threshold  <= ftmc_pkg::ALARM_RESET;
         cfg_ff.high_threshold   <= ftmc_pkg::HIGH_RESET;
         cfg_ff.normal_threshold <= ftmc_pkg::NORMAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The whole tick is one pass of combinational logic.
   ftmc_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg         (cfg_ff),
      .temperature (req_tdata[ftmc_pkg::TEMP_WIDTH-1:0]),
      .flags_cur   (flags_ff),
      .scan_cur    (scan_ff),
      .log_cur     (log_ff),
      .pwait_cur   (pwait_ff),
      .prun_cur    (prun_ff),
      .oheat_cur   (oheat_ff),
      .flags_nxt   (flags_in),
      .scan_nxt    (scan_in),
      .log_nxt     (log_in),
      .pwait_nxt   (pwait_in),
      .prun_nxt    (prun_in),
      .oheat_nxt   (oheat_in),
      .result      (result_in)
   );

   // Tick state advances only on an input transfer. The scan and log counters
   // reset to zero, as do their period registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.mode       <= ftmc_pkg::MODE_IDLE;
         flags_ff.fan_cpu    <= 1'b0;
         flags_ff.fan_supply <= 1'b0;
         flags_ff.fan_front  <= 1'b0;
         flags_ff.fan_rear   <= 1'b0;
         flags_ff.led        <= 1'b0;
         flags_ff.halted     <= 1'b0;
         scan_ff             <= '0;
         log_ff              <= '0;
         pwait_ff            <= '0;
         prun_ff             <= '0;
         oheat_ff            <= '0;
      end else if (req_take) begin
         flags_ff <= flags_in;
         scan_ff  <= scan_in;
         log_ff   <= log_in;
         pwait_ff <= pwait_in;
         prun_ff  <= prun_in;
         oheat_ff <= oheat_in;
      end
   end

   // Output register: refilled on every input transfer, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   // Once halted, only reset releases the block.
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      flags_ff.halted |=> flags_ff.halted)
      else $error("halt flag cleared without reset");

   // A halted block leaves mode, LED and the CPU and rear fans untouched on further ticks.
   a_halt_frozen : assert property (@(posedge clock) disable iff (reset)
      (flags_ff.halted && req_take) |=>
         ($stable(flags_ff.mode) && $stable(flags_ff.fan_cpu) &&
          $stable(flags_ff.fan_rear) && $stable(flags_ff.led)))
      else $error("state changed while halted");

   // Waiting ticks report neither events nor log strobes.
   a_wait_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.scanned) |->
         (result_ff.event_code == ftmc_pkg::EV_NONE && !result_ff.log_strobe))
      else $error("event reported on a waiting tick");

   // The fan set matches the mode: all fans on in alarm mode, all off in idle.
   a_fans_follow_mode : assert property (@(posedge clock) disable iff (reset)
      (flags_ff.mode == ftmc_pkg::MODE_ALARM) |->
         (flags_ff.fan_cpu && flags_ff.fan_supply && flags_ff.fan_front &&
          flags_ff.fan_rear))
      else $error("alarm mode without all fans on");

   a_idle_fans_off : assert property (@(posedge clock) disable iff (reset)
      (flags_ff.mode == ftmc_pkg::MODE_IDLE) |->
         !(flags_ff.fan_cpu || flags_ff.fan_supply || flags_ff.fan_front ||
           flags_ff.fan_rear))
      else $error("idle mode with a fan on");

endmodule
